FILE: design/tga_pkg.sv
// tga_pkg: shared types and constants of the tga image decoder
// used by tga_parser, tga_outq and tga_image_decoder_unit; depends on nothing else
package tga_pkg;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int PAL_DEPTH_DEF = 256;
    localparam int SIZE_W        = 27;
    localparam int HDR_LEN       = 18;
    localparam int MIN_FILE      = 19;
    localparam int Q_DEPTH       = 4;
    localparam int Q_AW          = 2;
    localparam int Q_CW          = 3;
    localparam int MAX_RES       = 2;

    localparam logic [7:0] TYPE_CMAP  = 8'h01;
    localparam logic [7:0] TYPE_TRUE  = 8'h02;
    localparam logic [7:0] TYPE_GREY  = 8'h03;
    localparam logic [7:0] BTYPE_MASK = 8'hF7;
    localparam logic [7:0] ATTR_RSVD  = 8'h10;
    localparam logic [7:0] ALPHA_MASK = 8'h0F;
    localparam logic [7:0] ALPHA_BITS = 8'd8;
    localparam logic [7:0] DEPTH_8    = 8'd8;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;

    typedef enum logic [1:0] {
        KIND_PIX,
        KIND_REJECT,
        KIND_TRUNC,
        KIND_OVERRUN
    } kind_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  repeat_res;
        kind_t       kind;
        logic        image_has_alpha;
        logic        last;
    } res_t;

    typedef struct packed {
        logic  run_v;
        logic  stat_v;
        kind_t stat_kind;
        logic  stat_ha;
        logic  pal_sel;
        res_t  run;
    } evt_t;

endpackage

FILE: design/tga_ram.sv
// tga_ram: generic single write port, single read port ram with registered read
// no dependencies
module tga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tga_parser.sv
// tga_parser: byte parser, header check, packet decode and palette write control
// depends on tga_pkg; drives the palette ram and the event register read by tga_outq
module tga_parser #(
    parameter int MAX_DIM       = tga_pkg::MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = tga_pkg::PAL_DEPTH_DEF,
    localparam int PAL_AW = $clog2(PALETTE_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [7:0]                   data_byte,
    input  logic                         first_of_file,
    input  logic                         cfg_wr_en,
    input  logic [tga_pkg::SIZE_W-1:0]   cfg_wr_data,
    output tga_pkg::evt_t                evt_q,
    output logic                         pal_we,
    output logic [PAL_AW-1:0]            pal_waddr,
    output logic [31:0]                  pal_wdata,
    output logic                         pal_re,
    output logic [PAL_AW-1:0]            pal_raddr,
    output logic                         pal_hit_q
);
    import tga_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CS_W   = ((DIM_W > 8) ? DIM_W : 8) + 1;
    localparam int NEED_W = 2 * DIM_W + 2;
    localparam int SUM_W  = ((NEED_W > SIZE_W) ? NEED_W : SIZE_W) + 1;
    localparam int PIDX_W = PAL_AW + 1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COMMENT,
        PH_CMAP,
        PH_PLAIN,
        PH_PKTHDR,
        PH_PKTDATA,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, ph_c, ph_n;
    logic [SIZE_W-1:0]   byte_count_reg, bc_c, bc_n, bc_out;
    logic [SIZE_W-1:0]   file_size_reg;
    logic [DIM_W-1:0]    col_reg, col_c, col_n;
    logic [DIM_W-1:0]    row_reg, row_c, row_n;
    logic [7:0]          pleft_reg, pleft_c, pleft_n;
    logic                prun_reg, prun_c, prun_n;
    logic [23:0]         pbytes_reg, pbytes_c, pbytes_n;
    logic [1:0]          pbi_reg, pbi_c, pbi_n;
    logic [PIDX_W-1:0]   pidx_reg, pidx_c, pidx_n;
    logic [7:0]          hdr_reg [HDR_LEN];
    logic [7:0]          hn [HDR_LEN];
    logic [NEED_W-1:0]   need_reg, need_calc;
    logic [2*DIM_W-1:0]  wh_mul;
    logic [DIM_W-1:0]    w_r, h_r;
    logic [2:0]          pl16;
    logic                pal_vld_reg [PALETTE_DEPTH];
    logic                pal_hit_reg;
    evt_t                evt_reg, ev;

    logic [7:0]          btype, attr, ps, cmesz;
    logic [15:0]         w16, h16, cmlen, cmfirst;
    logic [DIM_W-1:0]    w_d, h_d;
    logic                rle, alpha8, hdr_ok;
    logic [2:0]          pl, tb_len;
    logic [31:0]         tb_full, tb_shift;
    logic                tb_done;
    logic                hdr_we, pal_we_c, do_eb, do_put, stat_c;
    kind_t               stat_k;
    logic [31:0]         put_full;
    logic [7:0]          put_rep;
    logic [7:0]          cnt8;
    logic [9:0]          need_p;
    logic [CS_W-1:0]     col_sum;
    logic [DIM_W-1:0]    row_x;
    logic [7:0]          pa;

    // multiply width by height ahead of the last header byte
    always_comb begin
        w_r  = DIM_W'({hdr_reg[13], hdr_reg[12]});
        h_r  = DIM_W'({hdr_reg[15], hdr_reg[14]});
        wh_mul = w_r * h_r;
        if ((hdr_reg[2] & BTYPE_MASK) == TYPE_TRUE) begin
            pl16 = (data_byte == DEPTH_32) ? 3'd4 : 3'd3;
        end else begin
            pl16 = 3'd1;
        end
        unique case (pl16)
            3'd4:    need_calc = NEED_W'({wh_mul, 2'b00});
            3'd3:    need_calc = NEED_W'(wh_mul) + NEED_W'({wh_mul, 1'b0});
            default: need_calc = NEED_W'(wh_mul);
        endcase
    end

    always_comb begin
        ph_c     = first_of_file ? PH_HEADER : phase_reg;
        bc_c     = first_of_file ? '0 : byte_count_reg;
        col_c    = first_of_file ? '0 : col_reg;
        row_c    = first_of_file ? '0 : row_reg;
        pleft_c  = first_of_file ? '0 : pleft_reg;
        prun_c   = first_of_file ? 1'b0 : prun_reg;
        pbytes_c = first_of_file ? '0 : pbytes_reg;
        pbi_c    = first_of_file ? '0 : pbi_reg;
        pidx_c   = first_of_file ? '0 : pidx_reg;
        bc_n     = bc_c + 1'b1;

        for (int i = 0; i < HDR_LEN; i++) begin
            hn[i] = (ph_c == PH_HEADER && bc_c == SIZE_W'(i)) ? data_byte : hdr_reg[i];
        end

        btype   = hn[2] & BTYPE_MASK;
        rle     = hn[2][3];
        cmfirst = {hn[4], hn[3]};
        cmlen   = {hn[6], hn[5]};
        cmesz   = hn[7];
        w16     = {hn[13], hn[12]};
        h16     = {hn[15], hn[14]};
        ps      = hn[16];
        attr    = hn[17];
        alpha8  = (attr & ALPHA_MASK) == ALPHA_BITS;
        w_d     = DIM_W'(w16);
        h_d     = DIM_W'(h16);
        if (btype == TYPE_TRUE) begin
            pl = (ps == DEPTH_32) ? 3'd4 : 3'd3;
        end else begin
            pl = 3'd1;
        end

        hdr_ok = 1'b1;
        if (w16 == 16'd0 || w16 > 16'(MAX_DIM) || h16 == 16'd0 || h16 > 16'(MAX_DIM)) begin
            hdr_ok = 1'b0;
        end
        if (hn[1] != 8'd0) begin
            if (cmlen > 16'(PALETTE_DEPTH) || cmfirst != 16'd0) hdr_ok = 1'b0;
            if (cmesz != DEPTH_24 && cmesz != DEPTH_32) hdr_ok = 1'b0;
        end
        if (btype == TYPE_TRUE) begin
            if (ps != DEPTH_24 && ps != DEPTH_32) hdr_ok = 1'b0;
        end else if (btype == TYPE_CMAP || btype == TYPE_GREY) begin
            if (ps != DEPTH_8) hdr_ok = 1'b0;
        end else begin
            hdr_ok = 1'b0;
        end
        if ((attr & ATTR_RSVD) != 8'd0) hdr_ok = 1'b0;
        if ((attr & ALPHA_MASK) != 8'd0 && !alpha8) hdr_ok = 1'b0;

        tb_len   = (ph_c == PH_CMAP) ? ((cmesz == DEPTH_32) ? 3'd4 : 3'd3) : pl;
        tb_shift = 32'(data_byte) << {pbi_c, 3'b000};
        tb_full  = {8'h00, pbytes_c} | tb_shift;
        tb_done  = ({1'b0, pbi_c} + 3'd1) >= tb_len;

        cnt8 = {1'b0, data_byte[6:0]} + 8'd1;
        if (data_byte[7]) begin
            need_p = 10'(pl);
        end else begin
            unique case (pl)
                3'd4:    need_p = {cnt8, 2'b00};
                3'd3:    need_p = 10'(cnt8) + {1'b0, cnt8, 1'b0};
                default: need_p = 10'(cnt8);
            endcase
        end

        ph_n     = ph_c;
        bc_out   = bc_c;
        col_n    = col_c;
        row_n    = row_c;
        pleft_n  = pleft_c;
        prun_n   = prun_c;
        pbytes_n = pbytes_c;
        pbi_n    = pbi_c;
        pidx_n   = pidx_c;
        ev       = '0;
        hdr_we   = 1'b0;
        pal_we_c = 1'b0;
        do_eb    = 1'b0;
        do_put   = 1'b0;
        stat_c   = 1'b0;
        stat_k   = KIND_PIX;
        put_full = tb_full;
        put_rep  = 8'd1;
        col_sum  = '0;
        row_x    = '0;
        pa       = 8'hFF;

        if (ph_c == PH_DONE) begin
            ph_n = PH_DONE;
        end else if (ph_c == PH_HEADER && bc_c == '0 && file_size_reg < SIZE_W'(MIN_FILE)) begin
            stat_c = 1'b1;
            stat_k = KIND_REJECT;
        end else begin
            bc_out = bc_n;
            if (ph_c == PH_CMAP || ph_c == PH_PLAIN || ph_c == PH_PKTDATA) begin
                if (tb_done) begin
                    pbytes_n = '0;
                    pbi_n    = '0;
                end else begin
                    pbytes_n = tb_full[23:0];
                    pbi_n    = pbi_c + 2'd1;
                end
            end
            unique case (ph_c)
                PH_HEADER: begin
                    hdr_we = bc_c < SIZE_W'(HDR_LEN);
                    if (bc_n >= SIZE_W'(HDR_LEN)) begin
                        if (!hdr_ok) begin
                            stat_c = 1'b1;
                            stat_k = KIND_REJECT;
                        end else begin
                            do_eb = 1'b1;
                        end
                    end
                end
                PH_COMMENT: begin
                    do_eb = 1'b1;
                end
                PH_CMAP: begin
                    if (tb_done) begin
                        pal_we_c = 1'b1;
                        pidx_n   = pidx_c + 1'b1;
                        do_eb    = 1'b1;
                    end
                end
                PH_PLAIN: begin
                    do_put = tb_done;
                end
                PH_PKTHDR: begin
                    if (SUM_W'(bc_n) + SUM_W'(need_p) > SUM_W'(file_size_reg)) begin
                        stat_c = 1'b1;
                        stat_k = KIND_TRUNC;
                    end else if (CS_W'(col_c) + CS_W'(cnt8) > CS_W'(w_d)) begin
                        stat_c = 1'b1;
                        stat_k = KIND_OVERRUN;
                    end else begin
                        prun_n   = data_byte[7];
                        pleft_n  = cnt8;
                        pbytes_n = '0;
                        pbi_n    = '0;
                        ph_n     = PH_PKTDATA;
                    end
                end
                PH_PKTDATA: begin
                    if (tb_done) begin
                        do_put = 1'b1;
                        if (prun_c) begin
                            put_rep = pleft_c;
                            pleft_n = '0;
                            ph_n    = PH_PKTHDR;
                        end else begin
                            pleft_n = (pleft_c != 8'd0) ? pleft_c - 8'd1 : 8'd0;
                            if (pleft_n == 8'd0) ph_n = PH_PKTHDR;
                        end
                    end
                end
                default: begin
                    ph_n = PH_DONE;
                end
            endcase
        end

        if (do_eb) begin
            if (bc_n < SIZE_W'(HDR_LEN) + SIZE_W'(hn[0])) begin
                ph_n = PH_COMMENT;
            end else if (hn[1] != 8'd0 && 16'(pidx_n) < cmlen) begin
                ph_n = PH_CMAP;
            end else begin
                pbytes_n = '0;
                pbi_n    = '0;
                if (rle) begin
                    ph_n = PH_PKTHDR;
                end else begin
                    ph_n = PH_PLAIN;
                    if (SUM_W'(bc_n) + SUM_W'(need_reg) > SUM_W'(file_size_reg)) begin
                        stat_c = 1'b1;
                        stat_k = KIND_TRUNC;
                    end
                end
            end
        end

        if (do_put) begin
            ev.run_v   = 1'b1;
            ev.pal_sel = 1'b0;
            if (btype == TYPE_TRUE) begin
                ev.run.blue  = put_full[7:0];
                ev.run.green = put_full[15:8];
                ev.run.red   = put_full[23:16];
                ev.run.alpha = (pl == 3'd4 && alpha8) ? put_full[31:24] : 8'hFF;
            end else if (btype == TYPE_GREY) begin
                ev.run.red   = put_full[7:0];
                ev.run.green = put_full[7:0];
                ev.run.blue  = put_full[7:0];
                ev.run.alpha = 8'hFF;
            end else begin
                ev.pal_sel = 1'b1;
            end
            row_x = attr[5] ? row_c : h_d - DIM_W'(1) - row_c;
            ev.run.column          = 12'(col_c);
            ev.run.row             = 12'(row_x);
            ev.run.repeat_res      = put_rep;
            ev.run.kind            = KIND_PIX;
            ev.run.image_has_alpha = alpha8;
            col_sum = CS_W'(col_c) + CS_W'(put_rep);
            if (col_sum >= CS_W'(w_d)) begin
                col_n = '0;
                row_n = row_c + 1'b1;
                if ((DIM_W + 1)'(row_c) + 1'b1 >= (DIM_W + 1)'(h_d)) begin
                    ev.run.last = 1'b1;
                    ph_n        = PH_DONE;
                end
            end else begin
                col_n = DIM_W'(col_sum);
            end
        end

        if (!stat_c && ph_n != PH_DONE && bc_n >= file_size_reg) begin
            stat_c = 1'b1;
            stat_k = KIND_TRUNC;
        end
        ev.stat_ha = (ph_n != PH_HEADER) && alpha8;
        if (stat_c) begin
            ev.stat_v    = 1'b1;
            ev.stat_kind = stat_k;
            ph_n         = PH_DONE;
        end

        pa = (tb_len == 3'd4) ? tb_full[31:24] : 8'hFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            byte_count_reg <= '0;
            file_size_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pleft_reg      <= '0;
            prun_reg       <= 1'b0;
            pbytes_reg     <= '0;
            pbi_reg        <= '0;
            pidx_reg       <= '0;
            evt_reg        <= '0;
            pal_hit_reg    <= 1'b0;
            for (int i = 0; i < PALETTE_DEPTH; i++) begin
                pal_vld_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                file_size_reg <= cfg_wr_data;
            end
            evt_reg <= accept ? ev : '0;
            if (accept) begin
                phase_reg      <= ph_n;
                byte_count_reg <= bc_out;
                col_reg        <= col_n;
                row_reg        <= row_n;
                pleft_reg      <= pleft_n;
                prun_reg       <= prun_n;
                pbytes_reg     <= pbytes_n;
                pbi_reg        <= pbi_n;
                pidx_reg       <= pidx_n;
                pal_hit_reg    <= pal_vld_reg[data_byte[PAL_AW-1:0]];
                if (pal_we_c) begin
                    pal_vld_reg[pidx_c[PAL_AW-1:0]] <= 1'b1;
                end
            end
        end
        if (accept && hdr_we) begin
            hdr_reg[bc_c[4:0]] <= data_byte;
        end
        if (accept && ph_c == PH_HEADER && bc_c == SIZE_W'(16)) begin
            need_reg <= need_calc;
        end
    end

    assign evt_q     = evt_reg;
    assign pal_hit_q = pal_hit_reg;
    assign pal_we    = accept && pal_we_c;
    assign pal_waddr = pidx_c[PAL_AW-1:0];
    assign pal_wdata = {tb_full[23:16], tb_full[15:8], tb_full[7:0], pa};
    assign pal_re    = accept;
    assign pal_raddr = data_byte[PAL_AW-1:0];

`ifndef SYNTH
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && phase_reg == PH_DONE && !(accept && first_of_file))
        |=> phase_reg == PH_DONE)
        else $error("finished file left done phase without a new file");
    a_stat_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (evt_reg.run_v && evt_reg.stat_v) |-> (evt_reg.stat_kind == KIND_TRUNC))
        else $error("status with a run is not a truncation");
    a_last_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (evt_reg.run_v && evt_reg.run.last) |-> !evt_reg.stat_v)
        else $error("status after the final pixel");
`endif

endmodule

FILE: design/tga_outq.sv
// tga_outq: palette color select and the result queue in front of the m_ port
// depends on tga_pkg; takes the event register of tga_parser and the palette ram data
module tga_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tga_pkg::evt_t          evt,
    input  logic [31:0]            pal_rdata,
    input  logic                   pal_hit,
    input  logic                   m_ready,
    output logic                   m_valid,
    output tga_pkg::res_t          m_res,
    output logic [tga_pkg::Q_CW-1:0] q_cnt
);
    import tga_pkg::*;

    res_t             q_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  cnt_reg, cnt_next;
    res_t             run_item, stat_item;
    logic [31:0]      entry;
    logic [Q_CW-1:0]  n_push;
    logic             pop;

    always_comb begin
        entry    = pal_hit ? pal_rdata : 32'h0;
        run_item = evt.run;
        if (evt.pal_sel) begin
            run_item.red   = entry[31:24];
            run_item.green = entry[23:16];
            run_item.blue  = entry[15:8];
            run_item.alpha = entry[7:0];
        end
        stat_item                 = '0;
        stat_item.kind            = evt.stat_kind;
        stat_item.image_has_alpha = evt.stat_ha;
        stat_item.last            = 1'b1;
        n_push   = Q_CW'(evt.run_v) + Q_CW'(evt.stat_v);
        pop      = m_valid && m_ready;
        cnt_next = cnt_reg + n_push - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_AW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + Q_AW'(pop);
            cnt_reg    <= cnt_next;
        end
        if (evt.run_v) begin
            q_reg[wr_ptr_reg] <= run_item;
        end
        if (evt.stat_v) begin
            q_reg[wr_ptr_reg + Q_AW'(evt.run_v)] <= stat_item;
        end
    end

    assign m_valid = cnt_reg != '0;
    assign m_res   = q_reg[rd_ptr_reg];
    assign q_cnt   = cnt_reg;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= Q_CW'(Q_DEPTH))
        else $error("result queue count out of range");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (4'(cnt_reg) + 4'(evt.run_v) + 4'(evt.stat_v)) <= 4'(Q_DEPTH))
        else $error("result queue overflow");
    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.kind != KIND_PIX) |-> (m_res.last && m_res.repeat_res == 8'd0))
        else $error("status request without last or with a repeat count");
`endif

endmodule

FILE: design/tga_image_decoder_unit.sv
// tga_image_decoder_unit: top level of the streaming tga decoder
// depends on tga_pkg, tga_parser, tga_ram and tga_outq
//
// Usage:
//   s_ channel: one file byte per request, s_first_of_file marks byte 0 of a
//   file and restarts the parser. m_ channel: one pixel run or status per
//   request (kind 0 run, 1 header rejected, 2 truncated, 3 row overrun).
//   cfg_wr_en/cfg_wr_data load the file length in bytes; write it before
//   byte 0 of a file.
//   Throughput: one byte per cycle while s_ready is high; a byte gives at most two results.
//   A taken byte passes one register stage in the parser with the palette
//   ram read and one in the result queue before m_valid rises.
//   A four deep result queue decouples the sides; s_ready drops only when
//   the queue could not take the worst case of two more results, so a
//   stalled receiver holds back the byte stream without losing anything.
//   Reset clears the parser, the file length and all palette valid bits;
//   palette entries never loaded read as zero. Palette contents persist
//   across files. No clearing pass is needed after reset.
module tga_image_decoder_unit #(
    parameter int MAX_DIM       = tga_pkg::MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = tga_pkg::PAL_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_first_of_file,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_red,
    output logic [7:0]                 m_green,
    output logic [7:0]                 m_blue,
    output logic [7:0]                 m_alpha,
    output logic [11:0]                m_column,
    output logic [11:0]                m_row,
    output logic [7:0]                 m_repeat_res,
    output logic [1:0]                 m_kind,
    output logic                       m_image_has_alpha,
    output logic                       m_last,
    input  logic                       cfg_wr_en,
    input  logic [tga_pkg::SIZE_W-1:0] cfg_wr_data
);
    import tga_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_DEPTH);

    logic              accept;
    evt_t              evt;
    logic              pal_we, pal_re, pal_hit;
    logic [PAL_AW-1:0] pal_waddr, pal_raddr;
    logic [31:0]       pal_wdata, pal_rdata;
    logic [Q_CW-1:0]   q_cnt;
    res_t              res;

    assign s_ready = (q_cnt + Q_CW'(evt.run_v) + Q_CW'(evt.stat_v))
                     <= Q_CW'(Q_DEPTH - MAX_RES);
    assign accept  = s_valid && s_ready;

    tga_parser #(
        .MAX_DIM       (MAX_DIM),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .data_byte     (s_data_byte),
        .first_of_file (s_first_of_file),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .evt_q         (evt),
        .pal_we        (pal_we),
        .pal_waddr     (pal_waddr),
        .pal_wdata     (pal_wdata),
        .pal_re        (pal_re),
        .pal_raddr     (pal_raddr),
        .pal_hit_q     (pal_hit)
    );

    tga_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (aclk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .re    (pal_re),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    tga_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .evt       (evt),
        .pal_rdata (pal_rdata),
        .pal_hit   (pal_hit),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (res),
        .q_cnt     (q_cnt)
    );

    assign m_red             = res.red;
    assign m_green           = res.green;
    assign m_blue            = res.blue;
    assign m_alpha           = res.alpha;
    assign m_column          = res.column;
    assign m_row             = res.row;
    assign m_repeat_res      = res.repeat_res;
    assign m_kind            = res.kind;
    assign m_image_has_alpha = res.image_has_alpha;
    assign m_last            = res.last;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for tga_image_decoder_unit, built from tga files
// generated on the fly; a run predictor checks every result request in order
// depends on tga_pkg and the decoder rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tga_pkg::*;

    localparam int unsigned SIZE_MASK = 32'h7FF_FFFF;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef enum int {
        PH_HEADER, PH_COMMENT, PH_CMAP, PH_PLAIN, PH_PKTHDR, PH_PKTDATA, PH_DONE
    } phase_t;

    class tga_run_checker;
        bit [31:0]   pal [256];
        int unsigned fsize, bcnt, cur_col, cur_row, pkt_left, pix_acc, pix_idx, pal_idx;
        bit          pkt_run;
        phase_t      phase;
        bit [7:0]    hdr [24];
        res_t        pending_runs [$];
        int          errors;

        function new();
            foreach (pal[i]) pal[i] = '0;
            fsize = 0;
            errors = 0;
            start_file();
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function void start_file();
            bcnt = 0; phase = PH_HEADER; cur_col = 0; cur_row = 0; pkt_left = 0;
            pkt_run = 0; pix_acc = 0; pix_idx = 0; pal_idx = 0;
            foreach (hdr[i]) hdr[i] = '0;
        endfunction

        function int unsigned hw(int i);
            return {hdr[i+1], hdr[i]};
        endfunction

        function int unsigned btype();
            return hdr[2] & BTYPE_MASK;
        endfunction

        function bit alpha8();
            return (hdr[17] & ALPHA_MASK) == ALPHA_BITS;
        endfunction

        function int unsigned pix_len();
            return btype() == TYPE_TRUE ? hdr[16] / 8 : 1;
        endfunction

        function void emit(bit [31:0] rgba, int unsigned col, int unsigned row,
                           int unsigned rep, kind_t k, bit ha, bit lst);
            res_t r;
            r.red = rgba[31:24]; r.green = rgba[23:16]; r.blue = rgba[15:8];
            r.alpha = rgba[7:0]; r.column = col[11:0]; r.row = row[11:0];
            r.repeat_res = rep[7:0]; r.kind = k; r.image_has_alpha = ha; r.last = lst;
            pending_runs.push_back(r);
        endfunction

        function void status(kind_t k);
            emit('0, 0, 0, 0, k, phase != PH_HEADER && alpha8(), 1'b1);
            phase = PH_DONE;
        endfunction

        function bit header_ok();
            int unsigned t, w, h;
            t = btype(); w = hw(12); h = hw(14);
            if (w == 0 || w > MAX_DIM_DEF || h == 0 || h > MAX_DIM_DEF) return 0;
            if (hdr[1] != 0) begin
                if (hw(5) > 256 || hw(3) != 0) return 0;
                if (hdr[7] != DEPTH_24 && hdr[7] != DEPTH_32) return 0;
            end
            if (t == TYPE_TRUE) begin
                if (hdr[16] != DEPTH_24 && hdr[16] != DEPTH_32) return 0;
            end else if (t == TYPE_CMAP || t == TYPE_GREY) begin
                if (hdr[16] != DEPTH_8) return 0;
            end else begin
                return 0;
            end
            if ((hdr[17] & ATTR_RSVD) != 0) return 0;
            return (hdr[17] & ALPHA_MASK) == 0 || alpha8();
        endfunction

        function void enter_body();
            longint unsigned need;
            if (bcnt < HDR_LEN + hdr[0]) begin
                phase = PH_COMMENT;
                return;
            end
            if (hdr[1] != 0 && pal_idx < hw(5)) begin
                phase = PH_CMAP;
                return;
            end
            pix_acc = 0; pix_idx = 0;
            if (hdr[2][3]) begin
                phase = PH_PKTHDR;
                return;
            end
            need = longint'(hw(12)) * hw(14) * pix_len();
            phase = PH_PLAIN;
            if (longint'(bcnt) + need > longint'(fsize)) status(KIND_TRUNC);
        endfunction

        function bit gather(bit [7:0] d, int unsigned len, output bit [31:0] full);
            int unsigned i;
            i = pix_idx & 3;
            full = '0;
            if (i + 1 < len) begin
                pix_acc |= d << (8 * i);
                pix_idx = i + 1;
                return 0;
            end
            full = pix_acc | (d << (8 * i));
            pix_acc = 0; pix_idx = 0;
            return 1;
        endfunction

        function void put_run(bit [31:0] full, int unsigned rep);
            int unsigned t, w, h, row, col;
            bit [31:0] c;
            bit lst;
            t = btype(); w = hw(12); h = hw(14); lst = 0;
            if (t == TYPE_TRUE)
                c = {full[23:16], full[15:8], full[7:0],
                     (pix_len() == 4 && alpha8()) ? full[31:24] : 8'hFF};
            else if (t == TYPE_GREY)
                c = {full[7:0], full[7:0], full[7:0], 8'hFF};
            else
                c = pal[full[7:0]];
            row = hdr[17][5] ? cur_row : h - 1 - cur_row;
            col = cur_col;
            cur_col += rep;
            if (cur_col >= w) begin
                cur_col = 0;
                cur_row++;
                if (cur_row >= h) begin
                    lst = 1;
                    phase = PH_DONE;
                end
            end
            emit(c, col, row, rep, KIND_PIX, alpha8(), lst);
        endfunction

        function void note_byte(bit [7:0] d, bit first);
            int unsigned i, len, cnt, need, remain;
            bit [31:0] full;
            if (first) start_file();
            if (phase == PH_DONE) return;
            if (phase == PH_HEADER && bcnt == 0 && fsize < MIN_FILE) begin
                status(KIND_REJECT);
                return;
            end
            i = bcnt;
            bcnt = (bcnt + 1) & SIZE_MASK;
            case (phase)
                PH_HEADER: begin
                    if (i < HDR_LEN) hdr[i] = d;
                    if (bcnt >= HDR_LEN) begin
                        if (!header_ok()) begin
                            status(KIND_REJECT);
                            return;
                        end
                        enter_body();
                    end
                end
                PH_COMMENT: enter_body();
                PH_CMAP: begin
                    len = hdr[7] == DEPTH_32 ? 4 : 3;
                    if (gather(d, len, full)) begin
                        pal[pal_idx & 255] = {full[23:16], full[15:8], full[7:0],
                                              len == 4 ? full[31:24] : 8'hFF};
                        pal_idx++;
                        enter_body();
                    end
                end
                PH_PLAIN: if (gather(d, pix_len(), full)) put_run(full, 1);
                PH_PKTHDR: begin
                    cnt = (d & 8'h7F) + 1;
                    need = d[7] ? pix_len() : pix_len() * cnt;
                    remain = fsize > bcnt ? fsize - bcnt : 0;
                    if (remain < need) begin
                        status(KIND_TRUNC);
                        return;
                    end
                    if (cur_col + cnt > hw(12)) begin
                        status(KIND_OVERRUN);
                        return;
                    end
                    pkt_run = d[7]; pkt_left = cnt; pix_acc = 0; pix_idx = 0;
                    phase = PH_PKTDATA;
                end
                PH_PKTDATA: if (gather(d, pix_len(), full)) begin
                    if (pkt_run) begin
                        cnt = pkt_left;
                        pkt_left = 0;
                        phase = PH_PKTHDR;
                        put_run(full, cnt);
                    end else begin
                        if (pkt_left > 0) pkt_left--;
                        if (pkt_left == 0) phase = PH_PKTHDR;
                        put_run(full, 1);
                    end
                end
                default: phase = PH_DONE;
            endcase
            if (phase != PH_DONE && bcnt >= fsize) status(KIND_TRUNC);
        endfunction

        function void check_run(res_t got);
            res_t e;
            if (pending_runs.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            e = pending_runs.pop_front();
            if (got.red != e.red) report($sformatf("red %h exp %h", got.red, e.red));
            if (got.green != e.green) report($sformatf("green %h exp %h", got.green, e.green));
            if (got.blue != e.blue) report($sformatf("blue %h exp %h", got.blue, e.blue));
            if (got.alpha != e.alpha) report($sformatf("alpha %h exp %h", got.alpha, e.alpha));
            if (got.column != e.column)
                report($sformatf("column %0d exp %0d", got.column, e.column));
            if (got.row != e.row) report($sformatf("row %0d exp %0d", got.row, e.row));
            if (got.repeat_res != e.repeat_res)
                report($sformatf("repeat %0d exp %0d", got.repeat_res, e.repeat_res));
            if (got.kind != e.kind) report($sformatf("kind %0d exp %0d", got.kind, e.kind));
            if (got.image_has_alpha != e.image_has_alpha)
                report($sformatf("has_alpha %0b exp %0b", got.image_has_alpha,
                                 e.image_has_alpha));
            if (got.last != e.last) report($sformatf("last %0b exp %0b", got.last, e.last));
        endfunction
    endclass

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_first_of_file;
    logic [7:0]  s_data_byte;
    logic        m_valid, m_ready;
    logic [7:0]  m_red, m_green, m_blue, m_alpha, m_repeat_res;
    logic [11:0] m_column, m_row;
    logic [1:0]  m_kind;
    logic        m_image_has_alpha, m_last;
    logic        cfg_wr_en;
    logic [SIZE_W-1:0] cfg_wr_data;

    tga_run_checker runs = new();
    int unsigned    cycles = 0;
    int unsigned    rx_hold = 0;
    bit             calm = 0;
    int unsigned    bytes_sent = 0;

    tga_image_decoder_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_first_of_file(s_first_of_file),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue), .m_alpha(m_alpha),
        .m_column(m_column), .m_row(m_row), .m_repeat_res(m_repeat_res),
        .m_kind(m_kind), .m_image_has_alpha(m_image_has_alpha), .m_last(m_last),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // result side: check accepted requests, random stalls
    always @(posedge aclk) begin
        int unsigned r;
        bit rdy;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            if (aresetn && m_valid && m_ready)
                runs.check_run({m_red, m_green, m_blue, m_alpha, m_column, m_row,
                                m_repeat_res, kind_t'(m_kind), m_image_has_alpha, m_last});
            rdy = 1;
            if (rx_hold > 0) begin
                rx_hold--;
                rdy = 0;
            end else if (!calm) begin
                r = $urandom_range(0, 99);
                if (r >= 95) begin
                    rx_hold = $urandom_range(10, 40);
                    rdy = 0;
                end else if (r >= 70) begin
                    rx_hold = $urandom_range(0, 2);
                    rdy = 0;
                end
            end
            m_ready <= rdy;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_byte(bit [7:0] d, bit first);
        int unsigned gap;
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_first_of_file <= first;
        do @(posedge aclk); while (!s_ready);
        runs.note_byte(d, first);
        bytes_sent++;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (runs.pending_runs.size() > 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_size(int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[SIZE_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        runs.fsize = v & SIZE_MASK;
    endtask

    task automatic make_image(ref bit [7:0] f[$], input int unsigned itype, w, h, depth,
                              cmap_bits, cmap_len, attr, id_len, bit overrun);
        int unsigned plen, col, cnt, rem, nb;
        bit run;
        f.delete();
        f.push_back(id_len[7:0]);
        f.push_back(cmap_bits != 0);
        f.push_back(itype[7:0]);
        f.push_back(8'h00); f.push_back(8'h00);
        f.push_back(cmap_len[7:0]); f.push_back(cmap_len[15:8]);
        f.push_back(cmap_bits[7:0]);
        repeat (4) f.push_back($urandom_range(0, 255));
        f.push_back(w[7:0]); f.push_back(w[15:8]);
        f.push_back(h[7:0]); f.push_back(h[15:8]);
        f.push_back(depth[7:0]); f.push_back(attr[7:0]);
        repeat (id_len) f.push_back($urandom_range(0, 255));
        if (cmap_bits != 0) repeat (cmap_len * cmap_bits / 8) f.push_back($urandom_range(0, 255));
        plen = (itype & 7) == 2 ? depth / 8 : 1;
        if (itype[3]) begin
            repeat (h) begin
                col = 0;
                while (col < w) begin
                    rem = w - col;
                    cnt = $urandom_range(1, rem < 128 ? rem : 128);
                    if (overrun && rem < 128 && $urandom_range(0, 3) == 0)
                        cnt = $urandom_range(rem + 1, 128);
                    run = $urandom_range(0, 1);
                    f.push_back({run, 7'(cnt - 1)});
                    nb = run ? plen : plen * cnt;
                    repeat (nb) f.push_back($urandom_range(0, 255));
                    col += cnt;
                end
            end
        end else begin
            repeat (w * h * plen) f.push_back($urandom_range(0, 255));
        end
    endtask

    task automatic play_file(ref bit [7:0] f[$], input int unsigned fsize, bit first_flag);
        wait_idle();
        write_size(fsize);
        foreach (f[i]) send_byte(f[i], i == 0 ? first_flag : 1'b0);
    endtask

    task automatic random_file();
        bit [7:0] f[$];
        int unsigned itype, w, h, depth, cb, cl, attr, idl, r, fs;
        itype = $urandom_range(0, 5);
        itype = itype < 3 ? itype + 1 : itype + 6;
        w = $urandom_range(0, 9) == 0 ? $urandom_range(129, 200) : $urandom_range(1, 12);
        h = w > 12 ? 1 : $urandom_range(1, 6);
        depth = (itype & 7) == 2 ? ($urandom_range(0, 1) ? 32 : 24) : 8;
        cb = ((itype & 7) == 1 || $urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 32 : 24) : 0;
        cl = $urandom_range(0, 15) == 0 ? 64 : $urandom_range(1, 16);
        attr = ($urandom_range(0, 1) ? 8 : 0) | ($urandom_range(0, 3) << 5)
             | ($urandom_range(0, 1) << 7);
        idl = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        r = $urandom_range(0, 99);
        make_image(f, itype, w, h, depth, cb, cl, attr, idl, r >= 85 && r < 93);
        if (r >= 70 && r < 85) f[$urandom_range(0, 17)] = $urandom_range(0, 255);
        if (r >= 93) begin
            f.delete();
            repeat ($urandom_range(1, 40)) f.push_back($urandom_range(0, 255));
        end
        r = $urandom_range(0, 99);
        if (r < 75) fs = f.size();
        else if (r < 85) fs = $urandom_range(19, f.size());
        else if (r < 95) begin
            fs = f.size() + $urandom_range(1, 6);
            repeat ($urandom_range(0, 8)) f.push_back($urandom_range(0, 255));
        end else fs = $urandom_range(0, 18);
        play_file(f, fs, 1'b1);
        // stray bytes after the file; a finished file ignores them until the next first byte
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte($urandom_range(0, 255), 1'b0);
    endtask

    initial begin
        bit [7:0] f[$];
        aclk = 0; aresetn = 0; s_valid = 0; s_data_byte = 0; s_first_of_file = 0;
        m_ready = 0; cfg_wr_en = 0; cfg_wr_data = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed files
        make_image(f, 2, 2, 2, 24, 0, 0, 0, 0, 0);
        play_file(f, f.size(), 1'b0);
        play_file(f, 5, 1'b1);
        play_file(f, 0, 1'b1);
        make_image(f, 2, 3, 2, 32, 0, 0, 8'h28, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 2, 2, 2, 32, 0, 0, 8'h00, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 1, 3, 2, 8, 24, 4, 8'h20, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 1, 2, 2, 8, 32, 20, 8'h08, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 3, 2, 3, 8, 0, 0, 0, 40, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 9, 5, 2, 8, 32, 8, 8'h08, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 10, 7, 3, 24, 0, 0, 0, 0, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 10, 6, 2, 32, 0, 0, 8'h28, 3, 0);
        play_file(f, f.size(), 1'b1);
        make_image(f, 11, 130, 1, 8, 0, 0, 0, 0, 0);
        play_file(f, f.size(), 1'b1);
        // largest width and height, cut short after the first pixels
        make_image(f, 11, 4096, 1, 8, 0, 0, 8'h20, 0, 0);
        f = f[0:79];
        play_file(f, f.size(), 1'b1);
        make_image(f, 3, 1, 4096, 8, 0, 0, 0, 0, 0);
        f = f[0:79];
        play_file(f, SIZE_MASK, 1'b1);
        make_image(f, 3, 2, 2, 8, 0, 0, 0, 0, 0);
        play_file(f, f.size() - 1, 1'b1);
        make_image(f, 10, 20, 2, 24, 0, 0, 0, 0, 0);
        play_file(f, f.size() - 2, 1'b1);
        make_image(f, 11, 20, 3, 8, 0, 0, 0, 0, 1);
        f[18] = 8'h7F;
        play_file(f, f.size(), 1'b1);
        make_image(f, 2, 2, 2, 24, 0, 0, 0, 0, 0);
        f[12] = 0;  play_file(f, f.size(), 1'b1);
        f[12] = 2;  f[14] = 8'h01; f[15] = 8'h10; play_file(f, f.size(), 1'b1);
        f[14] = 2;  f[15] = 0; f[2] = 4; play_file(f, f.size(), 1'b1);
        f[2] = 2;   f[17] = ATTR_RSVD; play_file(f, f.size(), 1'b1);
        f[17] = 4;  play_file(f, f.size(), 1'b1);
        f[17] = 0;  f[16] = 16; play_file(f, f.size(), 1'b1);
        make_image(f, 1, 2, 2, 8, 24, 2, 0, 0, 0);
        f[3] = 1;   play_file(f, f.size(), 1'b1);
        f[3] = 0;   f[7] = 16; play_file(f, f.size(), 1'b1);
        f[7] = 24;  f[16] = 16; play_file(f, f.size(), 1'b1);

        // random files; each is played without idling on either side with a chance of one in eight
        while (bytes_sent < 1450) begin
            calm = $urandom_range(0, 7) == 0;
            random_file();
        end
        calm = 0;

        s_valid <= 1'b0;
        while (runs.pending_runs.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (runs.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: files.f
design/tga_pkg.sv
design/tga_ram.sv
design/tga_parser.sv
design/tga_outq.sv
design/tga_image_decoder_unit.sv
tb/tb_top.sv
